// ===== rtl/core/cr_pkg.sv =====
// package for the circle rasterizer: widths, sequencer opcodes and control program
`default_nettype none
package cr_pkg;

	localparam int RADIUS_BITS_DEF = 12;
	localparam int CENTER_W = 14;
	localparam int RADIUS_W = 12;
	localparam int COORD_W = 15;
	localparam int SW = 5;

	typedef enum logic [2:0] {
		OP_WAIT,
		OP_NONE,
		OP_INC,
		OP_SQ,
		OP_CMP,
		OP_BR,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t           op;
		logic [SW-1:0] nxt;
		logic [SW-1:0] alt;
		logic          xo_ty;
		logic          x_neg;
		logic          span;
		logic          yo_tx;
		logic          y_neg;
		logic          last;
	} cw_t;

	localparam logic [SW-1:0] S_WAIT  = 5'd0;
	localparam logic [SW-1:0] S_NONE  = 5'd1;
	localparam logic [SW-1:0] S_INC   = 5'd2;
	localparam logic [SW-1:0] S_SQ    = 5'd3;
	localparam logic [SW-1:0] S_CMP   = 5'd4;
	localparam logic [SW-1:0] S_BR    = 5'd5;
	localparam logic [SW-1:0] S_OUT0  = 5'd6;
	localparam logic [SW-1:0] S_FILL0 = 5'd14;

	function automatic cw_t cw_make(input op_t op, input logic [SW-1:0] nxt,
			input logic [SW-1:0] alt);
		cw_t c;
		c = '0;
		c.op = op;
		c.nxt = nxt;
		c.alt = alt;
		return c;
	endfunction

	function automatic cw_t cw_emit(input logic xo_ty, input logic x_neg, input logic span,
			input logic yo_tx, input logic y_neg, input logic last, input logic [SW-1:0] nxt);
		cw_t c;
		c = cw_make(OP_EMIT, nxt, S_WAIT);
		c.xo_ty = xo_ty;
		c.x_neg = x_neg;
		c.span = span;
		c.yo_tx = yo_tx;
		c.y_neg = y_neg;
		c.last = last;
		return c;
	endfunction

	function automatic cw_t cw_rom(input logic [SW-1:0] s);
		cw_t c;
		case (s)
			5'd0:  c = cw_make(OP_WAIT, S_INC, S_NONE);
			5'd1:  c = cw_make(OP_NONE, S_WAIT, S_WAIT);
			5'd2:  c = cw_make(OP_INC, S_SQ, S_SQ);
			5'd3:  c = cw_make(OP_SQ, S_CMP, S_CMP);
			5'd4:  c = cw_make(OP_CMP, S_BR, S_SQ);
			5'd5:  c = cw_make(OP_BR, S_OUT0, S_FILL0);
			// outline: eight points
			5'd6:  c = cw_emit(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd7);
			5'd7:  c = cw_emit(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 5'd8);
			5'd8:  c = cw_emit(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 5'd9);
			5'd9:  c = cw_emit(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 5'd10);
			5'd10: c = cw_emit(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 5'd11);
			5'd11: c = cw_emit(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 5'd12);
			5'd12: c = cw_emit(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 5'd13);
			5'd13: c = cw_emit(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, S_WAIT);
			// filled: four spans
			5'd14: c = cw_emit(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 5'd15);
			5'd15: c = cw_emit(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 5'd16);
			5'd16: c = cw_emit(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 5'd17);
			5'd17: c = cw_emit(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, S_WAIT);
			default: c = cw_make(OP_WAIT, S_WAIT, S_WAIT);
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cr_in_if.sv =====
// input channel of the circle rasterizer
`default_nettype none
interface cr_in_if;
	import cr_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic signed [CENTER_W-1:0] center_x;
	logic signed [CENTER_W-1:0] center_y;
	logic [RADIUS_W-1:0]        radius;
	logic                       filled;

	modport source (output valid, output func, output center_x, output center_y,
		output radius, output filled, input ready);
	modport sink (input valid, input func, input center_x, input center_y,
		input radius, input filled, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cr_out_if.sv =====
// output channel of the circle rasterizer
`default_nettype none
interface cr_out_if;
	import cr_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] x_left;
	logic signed [COORD_W-1:0] x_right;
	logic signed [COORD_W-1:0] row_y;
	logic                      last_of_group;
	logic                      circle_finished;
	logic                      nothing_drawn;

	modport source (output valid, output x_left, output x_right, output row_y,
		output last_of_group, output circle_finished, output nothing_drawn, input ready);
	modport sink (input valid, input x_left, input x_right, input row_y,
		input last_of_group, input circle_finished, input nothing_drawn, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cr_coord.sv =====
// coordinate datapath: one point or span from center, offsets and control word
`default_nettype none
module cr_coord #(
	parameter int R = cr_pkg::RADIUS_BITS_DEF
) (
	input  cr_pkg::cw_t                          cw,
	input  logic signed [cr_pkg::CENTER_W-1:0]   cx,
	input  logic signed [cr_pkg::CENTER_W-1:0]   cy,
	input  logic [R-1:0]                         tx,
	input  logic [R-1:0]                         ty,
	output logic signed [cr_pkg::COORD_W-1:0]    x_left,
	output logic signed [cr_pkg::COORD_W-1:0]    x_right,
	output logic signed [cr_pkg::COORD_W-1:0]    row_y
);
	import cr_pkg::*;

	localparam int EW = COORD_W + 1;

	logic [R-1:0]  a;
	logic [R-1:0]  b;
	logic [EW-1:0] a_e;
	logic [EW-1:0] b_e;
	logic [EW-1:0] cx_e;
	logic [EW-1:0] cy_e;
	logic [EW-1:0] x_plus;
	logic [EW-1:0] x_minus;
	logic [EW-1:0] y_val;

	always_comb begin
		a = cw.xo_ty ? ty : tx;
		b = cw.yo_tx ? tx : ty;
		a_e = {{(EW-R){1'b0}}, a};
		b_e = {{(EW-R){1'b0}}, b};
		cx_e = {{(EW-CENTER_W){cx[CENTER_W-1]}}, cx};
		cy_e = {{(EW-CENTER_W){cy[CENTER_W-1]}}, cy};
		x_plus = cx_e + a_e;
		x_minus = cx_e - a_e;
		y_val = cw.y_neg ? (cy_e - b_e) : (cy_e + b_e);
		if (cw.span) begin
			x_left = x_minus[COORD_W-1:0];
			x_right = x_plus[COORD_W-1:0];
		end else if (cw.x_neg) begin
			x_left = x_minus[COORD_W-1:0];
			x_right = x_minus[COORD_W-1:0];
		end else begin
			x_left = x_plus[COORD_W-1:0];
			x_right = x_plus[COORD_W-1:0];
		end
		row_y = y_val[COORD_W-1:0];
	end
endmodule
`default_nettype wire

// ===== rtl/core/circle_rasterizer.sv =====
// circle rasterizer top level: microcoded sequencer, state registers, output register
// start item: taken while the sequencer waits, no result
// advance item: taken, then the update steps INC, SQ, CMP (SQ and CMP again per major offset
//   decrement) and BR, then one result per cycle while output is free: 8 outline, 4 filled
// advance with no circle: one empty result via the NONE step, then the next item is taken
// arst_n clears the sequencer, all circle state and the output valid at once
`default_nettype none
module circle_rasterizer #(
	parameter int RADIUS_BITS = cr_pkg::RADIUS_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	cr_in_if.sink    req,
	cr_out_if.source rsp
);
	import cr_pkg::*;

	localparam int R = RADIUS_BITS;

	logic [SW-1:0]              step_q;
	logic signed [CENTER_W-1:0] cx_q;
	logic signed [CENTER_W-1:0] cy_q;
	logic [2*R-1:0]             rr_q;
	logic [R-1:0]               tx_q;
	logic [R-1:0]               ty_q;
	logic                       fill_q;
	logic                       active_q;
	logic [R-1:0]               txn_q;
	logic [R-1:0]               tyn_q;
	logic [2*R-1:0]             sqx_q;
	logic [2*R-1:0]             sqy_q;
	logic                       done_q;
	logic                       out_valid_q;
	logic signed [COORD_W-1:0]  xl_q;
	logic signed [COORD_W-1:0]  xr_q;
	logic signed [COORD_W-1:0]  y_q;
	logic                       last_q;
	logic                       fin_q;
	logic                       none_q;

	cw_t                        cw;
	logic [R-1:0]               r;
	logic [2*R:0]               sum;
	logic                       shrink;
	logic                       out_free;
	logic                       out_load;
	logic signed [COORD_W-1:0]  xl_c;
	logic signed [COORD_W-1:0]  xr_c;
	logic signed [COORD_W-1:0]  y_c;

	generate
		if (R <= RADIUS_W) begin : g_rtrunc
			assign r = req.radius[R-1:0];
		end else begin : g_rext
			assign r = {{(R-RADIUS_W){1'b0}}, req.radius};
		end
	endgenerate

	assign cw = cw_rom(step_q);
	assign sum = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign shrink = (txn_q != '0) && (sum > {1'b0, rr_q});
	assign out_free = !out_valid_q || rsp.ready;
	assign out_load = ((cw.op == OP_NONE) || (cw.op == OP_EMIT)) && out_free;
	assign req.ready = (cw.op == OP_WAIT);

	cr_coord #(.R(R)) u_coord (
		.cw      (cw),
		.cx      (cx_q),
		.cy      (cy_q),
		.tx      (tx_q),
		.ty      (ty_q),
		.x_left  (xl_c),
		.x_right (xr_c),
		.row_y   (y_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_WAIT;
			cx_q <= '0;
			cy_q <= '0;
			rr_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
			fill_q <= 1'b0;
			active_q <= 1'b0;
			done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (cw.op)
				OP_WAIT: begin
					if (req.valid) begin
						if (!req.func) begin
							cx_q <= req.center_x;
							cy_q <= req.center_y;
							fill_q <= req.filled;
							rr_q <= {{R{1'b0}}, r} * {{R{1'b0}}, r};
							ty_q <= '0;
							if (r == '0) begin
								tx_q <= '0;
								active_q <= 1'b0;
							end else begin
								tx_q <= r - {{(R-1){1'b0}}, 1'b1};
								active_q <= 1'b1;
							end
						end else if (active_q) begin
							step_q <= cw.nxt;
						end else begin
							step_q <= cw.alt;
						end
					end
				end
				OP_NONE: begin
					if (out_free) begin
						step_q <= cw.nxt;
					end
				end
				OP_INC: step_q <= cw.nxt;
				OP_SQ: step_q <= cw.nxt;
				OP_CMP: step_q <= shrink ? cw.alt : cw.nxt;
				OP_BR: begin
					done_q <= tyn_q > txn_q;
					step_q <= fill_q ? cw.alt : cw.nxt;
				end
				OP_EMIT: begin
					if (out_free) begin
						step_q <= cw.nxt;
						if (cw.last) begin
							tx_q <= txn_q;
							ty_q <= tyn_q;
							active_q <= !done_q;
						end
					end
				end
				default: step_q <= S_WAIT;
			endcase
		end
	end

	// working registers and output payload
	always_ff @(posedge clk) begin
		case (cw.op)
			OP_INC: begin
				tyn_q <= ty_q + {{(R-1){1'b0}}, 1'b1};
				txn_q <= tx_q;
			end
			OP_SQ: begin
				sqx_q <= {{R{1'b0}}, txn_q} * {{R{1'b0}}, txn_q};
				sqy_q <= {{R{1'b0}}, tyn_q} * {{R{1'b0}}, tyn_q};
			end
			OP_CMP: begin
				if (shrink) begin
					txn_q <= txn_q - {{(R-1){1'b0}}, 1'b1};
				end
			end
			OP_NONE: begin
				if (out_free) begin
					xl_q <= '0;
					xr_q <= '0;
					y_q <= '0;
					last_q <= 1'b1;
					fin_q <= 1'b1;
					none_q <= 1'b1;
				end
			end
			OP_EMIT: begin
				if (out_free) begin
					xl_q <= xl_c;
					xr_q <= xr_c;
					y_q <= y_c;
					last_q <= cw.last;
					fin_q <= done_q;
					none_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.x_left = xl_q;
	assign rsp.x_right = xr_q;
	assign rsp.row_y = y_q;
	assign rsp.last_of_group = last_q;
	assign rsp.circle_finished = fin_q;
	assign rsp.nothing_drawn = none_q;

`ifndef SYNTHESIS
	a_active_order: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (ty_q <= tx_q))
		else $error("active circle with minor offset above major");

	a_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.func && active_q) |=> (step_q == S_INC))
		else $error("advance on active circle did not start update");

	a_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.op == OP_CMP && shrink) |=> (txn_q == $past(txn_q) - {{(R-1){1'b0}}, 1'b1}))
		else $error("major offset decrement lost");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.nothing_drawn) |->
			(rsp.x_left == '0 && rsp.x_right == '0 && rsp.row_y == '0 && rsp.last_of_group))
		else $error("empty result with coordinates");
`endif
endmodule
`default_nettype wire

// ===== tb/cr_tb_pkg.sv =====
// shared testbench types for the circle rasterizer: item codes and the result record
package cr_tb_pkg;

	typedef enum logic {
		FN_START = 1'b0,
		FN_STEP  = 1'b1
	} func_e;

	typedef struct packed {
		logic signed [cr_pkg::COORD_W-1:0] x_left;
		logic signed [cr_pkg::COORD_W-1:0] x_right;
		logic signed [cr_pkg::COORD_W-1:0] row_y;
		logic                              last_of_group;
		logic                              circle_finished;
		logic                              nothing_drawn;
	} raster_run_t;

endpackage

// ===== tb/cr_raster_check.sv =====
// circle rasterizer checker: watches both channels, predicts each step's points or spans, compares
module cr_raster_check (
	input  logic clk,
	input  logic arst_n,
	cr_in_if     req,
	cr_out_if    rsp,
	output int   pending,
	output int   failures
);
	timeunit 1ns;
	timeprecision 1ps;
	import cr_tb_pkg::*;

	localparam int RAD_MASK = (1 << cr_pkg::RADIUS_BITS_DEF) - 1;
	localparam int CW = cr_pkg::COORD_W;

	logic signed [cr_pkg::CENTER_W-1:0] org_x;
	logic signed [cr_pkg::CENTER_W-1:0] org_y;
	longint      rad_sq;
	int          major;
	int          minor;
	logic        fill_on;
	logic        drawing;
	raster_run_t expected_runs[$];
	int          mismatch_total = 0;

	assign failures = mismatch_total;

	function automatic raster_run_t make_run(input int xl, input int xr, input int y);
		raster_run_t run;
		run = '0;
		run.x_left = xl[CW-1:0];
		run.x_right = xr[CW-1:0];
		run.row_y = y[CW-1:0];
		return run;
	endfunction

	task automatic predict_item(input func_e fn,
			input logic signed [cr_pkg::CENTER_W-1:0] cx_in,
			input logic signed [cr_pkg::CENTER_W-1:0] cy_in,
			input logic [cr_pkg::RADIUS_W-1:0] rad_in, input logic fill_in);
		raster_run_t batch[8];
		int          count;
		int          cx;
		int          cy;
		int          tx;
		int          ty;
		int          r;
		logic        done;
		count = 0;
		if (fn == FN_START) begin
			r = int'(rad_in) & RAD_MASK;
			org_x = cx_in;
			org_y = cy_in;
			fill_on = fill_in;
			rad_sq = longint'(r) * longint'(r);
			minor = 0;
			major = (r == 0) ? 0 : r - 1;
			drawing = (r != 0);
		end else if (!drawing) begin
			batch[0] = make_run(0, 0, 0);
			batch[0].last_of_group = 1'b1;
			batch[0].circle_finished = 1'b1;
			batch[0].nothing_drawn = 1'b1;
			count = 1;
		end else begin
			cx = org_x;
			cy = org_y;
			tx = major;
			ty = minor;
			if (fill_on) begin
				batch[0] = make_run(cx - tx, cx + tx, cy + ty);
				batch[1] = make_run(cx - tx, cx + tx, cy - ty);
				batch[2] = make_run(cx - ty, cx + ty, cy + tx);
				batch[3] = make_run(cx - ty, cx + ty, cy - tx);
				count = 4;
			end else begin
				batch[0] = make_run(cx + tx, cx + tx, cy + ty);
				batch[1] = make_run(cx + tx, cx + tx, cy - ty);
				batch[2] = make_run(cx - tx, cx - tx, cy + ty);
				batch[3] = make_run(cx - tx, cx - tx, cy - ty);
				batch[4] = make_run(cx + ty, cx + ty, cy + tx);
				batch[5] = make_run(cx + ty, cx + ty, cy - tx);
				batch[6] = make_run(cx - ty, cx - ty, cy + tx);
				batch[7] = make_run(cx - ty, cx - ty, cy - tx);
				count = 8;
			end
			ty = ty + 1;
			while (tx > 0 && longint'(tx) * tx + longint'(ty) * ty > rad_sq)
				tx = tx - 1;
			major = tx;
			minor = ty;
			done = ty > tx;
			if (done)
				drawing = 1'b0;
			for (int k = 0; k < count; k++)
				batch[k].circle_finished = done;
			batch[count-1].last_of_group = 1'b1;
		end
		for (int k = 0; k < count; k++)
			expected_runs.push_back(batch[k]);
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatch_total++;
		end
	endtask

	task automatic check_run(input raster_run_t got);
		raster_run_t want;
		if (expected_runs.size() == 0) begin
			$error("unexpected result x_left %0d x_right %0d row_y %0d",
				got.x_left, got.x_right, got.row_y);
			mismatch_total++;
		end else begin
			want = expected_runs.pop_front();
			compare_field("x_left", int'(want.x_left), int'(got.x_left));
			compare_field("x_right", int'(want.x_right), int'(got.x_right));
			compare_field("row_y", int'(want.row_y), int'(got.row_y));
			compare_field("last_of_group", int'(want.last_of_group),
				int'(got.last_of_group));
			compare_field("circle_finished", int'(want.circle_finished),
				int'(got.circle_finished));
			compare_field("nothing_drawn", int'(want.nothing_drawn),
				int'(got.nothing_drawn));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		raster_run_t seen;
		if (!arst_n) begin
			org_x = '0;
			org_y = '0;
			rad_sq = 0;
			major = 0;
			minor = 0;
			fill_on = 1'b0;
			drawing = 1'b0;
			expected_runs.delete();
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				seen.x_left = rsp.x_left;
				seen.x_right = rsp.x_right;
				seen.row_y = rsp.row_y;
				seen.last_of_group = rsp.last_of_group;
				seen.circle_finished = rsp.circle_finished;
				seen.nothing_drawn = rsp.nothing_drawn;
				check_run(seen);
			end
			if (req.valid && req.ready)
				predict_item(func_e'(req.func), req.center_x, req.center_y, req.radius, req.filled);
			pending <= expected_runs.size();
		end
	end

endmodule

// ===== tb/circle_rasterizer_test.sv =====
// circle rasterizer testbench top: clock, reset, start and step stimulus, result stalls, verdict
module circle_rasterizer_test;
	timeunit 1ns;
	timeprecision 1ps;
	import cr_tb_pkg::*;

	localparam int ITEM_COUNT = 420;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_OFF_AT = 150;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int CW = cr_pkg::CENTER_W;
	localparam int RW = cr_pkg::RADIUS_W;

	logic clk;
	logic arst_n;
	logic hold_req;
	int   pending;
	int   failures;
	int   sent = 0;
	int   cycles = 0;

	cr_in_if  req_ch();
	cr_out_if rsp_ch();

	circle_rasterizer DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	cr_raster_check raster_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.pending (pending),
		.failures(failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic offer(input func_e fn, input logic signed [cr_pkg::CENTER_W-1:0] cx,
			input logic signed [cr_pkg::CENTER_W-1:0] cy,
			input logic [cr_pkg::RADIUS_W-1:0] rad, input logic fl);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.func <= fn;
		req_ch.center_x <= cx;
		req_ch.center_y <= cy;
		req_ch.radius <= rad;
		req_ch.filled <= fl;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
		if (sent == HOLD_OFF_AT)
			hold_req <= 1'b1;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic offer_step();
		logic [cr_pkg::CENTER_W-1:0] jx;
		logic [cr_pkg::CENTER_W-1:0] jy;
		logic [cr_pkg::RADIUS_W-1:0] jr;
		jx = CW'($urandom);
		jy = CW'($urandom);
		jr = RW'($urandom);
		offer(FN_STEP, jx, jy, jr, 1'($urandom_range(0, 1)));
	endtask

	task automatic draw_circle(input int rad, input int steps);
		logic [cr_pkg::CENTER_W-1:0] cx;
		logic [cr_pkg::CENTER_W-1:0] cy;
		cx = CW'($urandom);
		cy = CW'($urandom);
		offer(FN_START, cx, cy, RW'(rad), 1'($urandom_range(0, 1)));
		repeat (steps) offer_step();
	endtask

	// result side: random stalls, long open stretches, one long hold-off
	initial begin
		bit held;
		int on_len;
		int off_len;
		held = 1'b0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
					: $urandom_range(1, 8);
				off_len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 3);
				rsp_ch.ready <= 1'b1;
				repeat (on_len) @(posedge clk);
				if (off_len > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (off_len) @(posedge clk);
				end
			end
		end
	end

	initial begin
		int rad;
		int steps;
		int roll;
		logic [cr_pkg::CENTER_W-1:0] nx;
		logic [cr_pkg::CENTER_W-1:0] ny;
		logic [cr_pkg::RADIUS_W-1:0] nr;
		arst_n <= 1'b0;
		hold_req <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.func <= FN_START;
		req_ch.center_x <= '0;
		req_ch.center_y <= '0;
		req_ch.radius <= '0;
		req_ch.filled <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// step before any circle, then a zero radius
		offer(FN_STEP, 0, 0, 0, 1'b0);
		offer(FN_START, 5, -3, 0, 1'b0);
		offer(FN_STEP, 0, 0, 0, 1'b0);
		// unit radius at the corners, both modes, then a step past the end
		offer(FN_START, 8191, -8192, 1, 1'b0);
		repeat (2) offer(FN_STEP, 0, 0, 0, 1'b0);
		offer(FN_START, -8192, 8191, 1, 1'b1);
		repeat (2) offer(FN_STEP, -1, -1, 4095, 1'b1);
		// largest radius, restarted mid circle
		offer(FN_START, 8191, 8191, 4095, 1'b0);
		repeat (2) offer(FN_STEP, 0, 0, 0, 1'b0);
		offer(FN_START, -8192, -8192, 4095, 1'b1);
		repeat (2) offer(FN_STEP, 0, 0, 0, 1'b0);
		// major offset driven down to zero
		offer(FN_START, 0, 0, 3, 1'b1);
		repeat (4) offer(FN_STEP, 0, 0, 0, 1'b0);
		offer(FN_START, -100, 77, 2, 1'b0);
		repeat (3) offer(FN_STEP, 0, 0, 0, 1'b0);

		while (sent < ITEM_COUNT) begin
			roll = $urandom_range(0, 99);
			if (roll < 72) begin
				rad = $urandom_range(1, 48);
				steps = (rad * 181) / 256 + $urandom_range(1, 2);
				if ($urandom_range(0, 4) == 0)
					steps = $urandom_range(1, steps);
				draw_circle(rad, steps);
			end else if (roll < 82) begin
				draw_circle($urandom_range(0, 4095), $urandom_range(1, 4));
			end else if (roll < 86) begin
				draw_circle(0, $urandom_range(1, 2));
			end else begin
				nx = CW'($urandom);
				ny = CW'($urandom);
				nr = RW'($urandom);
				offer(func_e'($urandom_range(0, 1)), nx, ny, nr, 1'($urandom_range(0, 1)));
			end
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
